// ===== rtl/core/slq_pkg.sv =====
// Shared constants, item and queue status types, token kinds, and character classes of the SQL query lexer.
`timescale 1ns / 1ps

package slq_pkg;

   // Limits of the lexer.
   localparam int TEXT_CAP  = 256;   // a token holds at most TEXT_CAP-1 bytes
   localparam int TOKEN_CAP = 128;   // at most TOKEN_CAP-1 tokens per text
   localparam int TEXT_MAX  = 4096;  // bytes taken before the text counts as ended

   // Field and counter widths.
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 3;
   localparam int START_W = 12;
   localparam int LEN_W   = 8;
   localparam int SYM_W   = 16;
   localparam int POS_W   = $clog2(TEXT_MAX) + 1;
   localparam int CNT_W   = $clog2(TOKEN_CAP);
   localparam int RSP_W   = ((KIND_W + START_W + LEN_W + SYM_W + 7) / 8) * 8;

   // Item queue between the front and back ends.
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   // Token kinds.
   localparam logic [KIND_W-1:0] KIND_SYM = 3'd0;
   localparam logic [KIND_W-1:0] KIND_STR = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NUM = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ID  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_END = 3'd4;

   // Characters the back end looks at directly.
   localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
   localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
   localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
   localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;

   // Character classes assigned by the front end.
   typedef enum logic [2:0] {
      CLS_SPACE = 3'd0,   // space, TAB, LF, VT, FF, CR
      CLS_SYM   = 3'd1,   // single-character symbols ; = ( ) , *
      CLS_QUOTE = 3'd2,   // single quote
      CLS_HOLD  = 3'd3,   // < > ! - which need one byte of lookahead
      CLS_DIGIT = 3'd4,
      CLS_IDST  = 3'd5,   // letter, underscore, dot, backslash
      CLS_OTHER = 3'd6,
      CLS_ZERO  = 3'd7    // zero byte, ends the text
   } class_type;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              end_of_text;
      class_type         char_class;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== rtl/core/sql_query_lexer.sv =====
// SQL query lexer top level: byte stream in, token descriptors out.
// An accepted item is registered in the item queue, and its results in the result buffer.
// Throughput: one item per cycle while the result side is not stalled; an item that yields two
// results holds the back end until its first token is taken, since the result buffer hands out one token per cycle.
// Reset: synchronous, active high; clears the lexer state, the item queue and the result buffer.
`timescale 1ns / 1ps

module sql_query_lexer (
   input  logic                        clock,
   input  logic                        reset,
   // Input channel: one text byte or an end-of-text marker per item.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [slq_pkg::BYTE_W-1:0]  req_tdata,   // [7:0] text_byte
   input  logic                        req_tlast,   // end_of_text
   // Result channel: token descriptors, up to two per item.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [slq_pkg::RSP_W-1:0]   rsp_tdata,   // [2:0] token_kind, [14:3] token_start,
                                                    // [22:15] token_length,
                                                    // [38:23] symbol_chars, [39] zero
   output logic                        rsp_tlast    // last_of_run
);
   import slq_pkg::*;

   // The front end classifies each accepted byte and pushes it into a short queue.
   // The back end pops one item per cycle whenever its result buffer will be free,
   // so a stall on the result side backs up into the queue before the input sees it.
   q_status_type  q_status;
   logic          push;
   logic          pop;
   item_type      push_item;
   item_type      pop_item;

   slq_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .push_item  (push_item)
   );

   slq_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_status  (q_status)
   );

   // The back end holds the scan mode, the pending token, the byte position and the
   // token count, and produces up to two tokens per item (a flushed token followed by
   // a new symbol, or a flushed token followed by END).
   slq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_item     (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/core/slq_front.sv =====
// Front end: accepts text items and tags each byte with its character class.
`timescale 1ns / 1ps

module slq_front (
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [slq_pkg::BYTE_W-1:0]  req_tdata,
   input  logic                        req_tlast,
   input  slq_pkg::q_status_type       q_status,
   output logic                        push,
   output slq_pkg::item_type           push_item
);
   import slq_pkg::*;

   class_type cls;

   always_comb begin
      if (req_tdata == 8'h00) begin
         cls = CLS_ZERO;
      end else if (req_tdata inside {8'h20, [8'h09:8'h0D]}) begin
         cls = CLS_SPACE;
      end else if (req_tdata inside {8'h3B, 8'h3D, 8'h28, 8'h29, 8'h2C, 8'h2A}) begin
         cls = CLS_SYM;
      end else if (req_tdata == 8'h27) begin
         cls = CLS_QUOTE;
      end else if (req_tdata inside {CH_LT, CH_GT, CH_BANG, CH_MINUS}) begin
         cls = CLS_HOLD;
      end else if (req_tdata inside {[8'h30:8'h39]}) begin
         cls = CLS_DIGIT;
      end else if (req_tdata inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F, 8'h2E, 8'h5C}) begin
         cls = CLS_IDST;
      end else begin
         cls = CLS_OTHER;
      end
   end

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && !q_status.full;

   assign push_item.text_byte   = req_tdata;
   assign push_item.end_of_text = req_tlast;
   assign push_item.char_class  = cls;

endmodule

// ===== rtl/core/slq_fifo.sv =====
// Short item queue that decouples the front end from the lexer back end.
`timescale 1ns / 1ps

module slq_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  slq_pkg::item_type      push_item,
   input  logic                   pop,
   output slq_pkg::item_type      pop_item,
   output slq_pkg::q_status_type  q_status
);
   import slq_pkg::*;

   item_type                 slot_ff [Q_DEPTH];
   logic [Q_AW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]            count_ff, count_in;

   assign q_status.full  = (count_ff == (Q_AW+1)'(Q_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_item       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + Q_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/slq_back.sv =====
// Back end: lexer state machine, token count limit and the two-entry result buffer.
`timescale 1ns / 1ps

module slq_back (
   input  logic                         clock,
   input  logic                         reset,
   input  slq_pkg::q_status_type        q_status,
   input  slq_pkg::item_type            q_item,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [slq_pkg::RSP_W-1:0]    rsp_tdata,
   output logic                         rsp_tlast
);
   import slq_pkg::*;

   typedef enum logic [4:0] {
      MODE_IDLE = 5'b00001,
      MODE_HELD = 5'b00010,
      MODE_STR  = 5'b00100,
      MODE_NUM  = 5'b01000,
      MODE_ID   = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   length;
      logic [SYM_W-1:0]   sym;
   } token_type;

   typedef struct packed {
      token_type tok;
      logic      last;
   } out_type;

   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(TEXT_CAP - 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(TOKEN_CAP - 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(TEXT_MAX);
   localparam logic             DASH_ROOM = (TEXT_CAP > 2);

   mode_type              mode_ff, mode_in;
   logic [BYTE_W-1:0]     held_ff, held_in;
   logic [START_W-1:0]    begin_ff, begin_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  stop_ff, stop_in;
   out_type               ob_ff [2];
   out_type               ob_in [2];
   logic [1:0]            ob_cnt_ff, ob_cnt_in;

   logic [BYTE_W-1:0]     c;
   class_type             cls;
   logic [POS_W-1:0]      nxt_pos;
   logic                  pair_hit, dash_num, len_room, dash_cut;
   logic                  a_valid, b_sym, b_end, fresh, stop_after;
   logic                  a_emit, b_emit, stop1;
   logic [CNT_W-1:0]      cnt1;
   mode_type              eff_mode;
   logic [LEN_W-1:0]      eff_len;
   token_type             a_tok, b_tok, fl_tok, pair_tok;
   logic                  fl_valid;
   logic [1:0]            n_res;
   logic                  drain;

   assign c        = q_item.text_byte;
   assign cls      = q_item.char_class;
   assign nxt_pos  = pos_ff + POS_W'(1);
   assign len_room = (len_ff < LEN_LIMIT);
   assign pair_hit = ((held_ff == CH_LT) && ((c == CH_EQ) || (c == CH_GT)))
                  || (((held_ff == CH_GT) || (held_ff == CH_BANG)) && (c == CH_EQ));
   assign dash_num = (held_ff == CH_MINUS) && (cls == CLS_DIGIT);

   assign drain = (ob_cnt_ff != 2'd0) && rsp_tready;
   assign pop   = !q_status.empty && ((ob_cnt_ff == 2'd0) || ((ob_cnt_ff == 2'd1) && rsp_tready));

   // A minus before a digit with no room left flushes as a one-byte number.
   assign dash_cut = pop && !q_item.end_of_text && !stop_ff && (cls != CLS_ZERO)
                  && (pos_ff < POS_LIMIT) && (mode_ff == MODE_HELD) && !pair_hit
                  && dash_num && !DASH_ROOM;
   assign eff_mode = dash_cut ? MODE_NUM : mode_ff;
   assign eff_len  = dash_cut ? LEN_W'(1) : len_ff;

   // Token that a flush of the current scan produces.
   always_comb begin
      fl_valid      = 1'b0;
      fl_tok.kind   = KIND_SYM;
      fl_tok.start  = begin_ff;
      fl_tok.length = eff_len;
      fl_tok.sym    = '0;
      case (eff_mode)
         MODE_HELD: begin
            fl_valid      = (held_ff != CH_BANG);
            fl_tok.length = LEN_W'(1);
            fl_tok.sym    = {held_ff, 8'h00};
         end
         MODE_STR: begin
            fl_valid    = 1'b1;
            fl_tok.kind = KIND_STR;
         end
         MODE_NUM: begin
            fl_valid    = 1'b1;
            fl_tok.kind = KIND_NUM;
         end
         MODE_ID: begin
            fl_valid    = 1'b1;
            fl_tok.kind = KIND_ID;
         end
         default: begin
            fl_valid = 1'b0;
         end
      endcase
   end

   assign pair_tok.kind   = KIND_SYM;
   assign pair_tok.start  = begin_ff;
   assign pair_tok.length = LEN_W'(2);
   assign pair_tok.sym    = {held_ff, c};

   // One item: an optional flushed or paired token, then an optional symbol or END.
   always_comb begin
      mode_in    = mode_ff;
      held_in    = held_ff;
      begin_in   = begin_ff;
      len_in     = len_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      stop_in    = stop_ff;
      a_valid    = 1'b0;
      a_tok      = fl_tok;
      b_sym      = 1'b0;
      b_end      = 1'b0;
      fresh      = 1'b0;
      stop_after = 1'b0;

      if (pop) begin
         if (q_item.end_of_text) begin
            a_valid = fl_valid;
            b_end   = 1'b1;
         end else if (!stop_ff) begin
            if ((cls == CLS_ZERO) || (pos_ff >= POS_LIMIT)) begin
               a_valid    = fl_valid;
               mode_in    = MODE_IDLE;
               stop_after = 1'b1;
            end else begin
               pos_in = nxt_pos;
               case (mode_ff)
                  MODE_HELD: begin
                     if (pair_hit) begin
                        a_valid = 1'b1;
                        a_tok   = pair_tok;
                        mode_in = MODE_IDLE;
                     end else if (dash_num && DASH_ROOM) begin
                        mode_in = MODE_NUM;
                        len_in  = LEN_W'(2);
                     end else begin
                        a_valid = fl_valid;
                        fresh   = 1'b1;
                     end
                  end
                  MODE_NUM: begin
                     if ((cls == CLS_DIGIT) && len_room) begin
                        len_in = len_ff + LEN_W'(1);
                     end else begin
                        a_valid = fl_valid;
                        fresh   = 1'b1;
                     end
                  end
                  MODE_ID: begin
                     if (((cls == CLS_IDST) || (cls == CLS_DIGIT)) && len_room) begin
                        len_in = len_ff + LEN_W'(1);
                     end else begin
                        a_valid = fl_valid;
                        fresh   = 1'b1;
                     end
                  end
                  MODE_STR: begin
                     if (cls == CLS_QUOTE) begin
                        a_valid = 1'b1;
                        mode_in = MODE_IDLE;
                     end else if (len_room) begin
                        len_in = len_ff + LEN_W'(1);
                     end else begin
                        a_valid = 1'b1;
                        fresh   = 1'b1;
                     end
                  end
                  default: begin
                     fresh = 1'b1;
                  end
               endcase
            end
         end
      end

      // Count limit on the first token.
      a_emit = a_valid && !stop_ff && (cnt_ff < CNT_LIMIT);
      cnt1   = a_emit ? cnt_ff + CNT_W'(1) : cnt_ff;
      stop1  = stop_ff || (a_valid && (cnt_ff >= CNT_LIMIT)) || (a_emit && (cnt1 >= CNT_LIMIT));

      // Start of a fresh token on the current byte.
      if (fresh) begin
         mode_in = MODE_IDLE;
         if (!stop1) begin
            case (cls)
               CLS_SYM: begin
                  b_sym = 1'b1;
               end
               CLS_QUOTE: begin
                  mode_in  = MODE_STR;
                  begin_in = nxt_pos[START_W-1:0];
                  len_in   = '0;
               end
               CLS_HOLD: begin
                  mode_in  = MODE_HELD;
                  held_in  = c;
                  begin_in = pos_ff[START_W-1:0];
               end
               CLS_DIGIT: begin
                  mode_in  = MODE_NUM;
                  begin_in = pos_ff[START_W-1:0];
                  len_in   = LEN_W'(1);
               end
               CLS_IDST: begin
                  mode_in  = MODE_ID;
                  begin_in = pos_ff[START_W-1:0];
                  len_in   = LEN_W'(1);
               end
               default: begin
                  mode_in = MODE_IDLE;
               end
            endcase
         end
      end

      b_emit = b_sym && !stop1 && (cnt1 < CNT_LIMIT);
      cnt_in = b_emit ? cnt1 + CNT_W'(1) : cnt1;
      stop_in = stop1 || (b_sym && !stop1 && (cnt1 >= CNT_LIMIT))
             || (b_emit && (cnt_in >= CNT_LIMIT)) || stop_after;

      if (b_end) begin
         b_tok.kind   = KIND_END;
         b_tok.start  = pos_ff[START_W-1:0];
         b_tok.length = '0;
         b_tok.sym    = '0;
      end else begin
         b_tok.kind   = KIND_SYM;
         b_tok.start  = pos_ff[START_W-1:0];
         b_tok.length = LEN_W'(1);
         b_tok.sym    = {c, 8'h00};
      end

      // An end item restores the reset state.
      if (b_end) begin
         mode_in  = MODE_IDLE;
         held_in  = '0;
         begin_in = '0;
         len_in   = '0;
         pos_in   = '0;
         cnt_in   = '0;
         stop_in  = 1'b0;
      end
   end

   // Result buffer: two entries, refilled only when it will be empty.
   always_comb begin
      n_res     = 2'(a_emit) + 2'(b_emit || b_end);
      ob_in[0]  = ob_ff[0];
      ob_in[1]  = ob_ff[1];
      ob_cnt_in = ob_cnt_ff;
      if (pop) begin
         ob_in[0].tok  = a_emit ? a_tok : b_tok;
         ob_in[0].last = (n_res == 2'd1);
         ob_in[1].tok  = b_tok;
         ob_in[1].last = 1'b1;
         ob_cnt_in     = n_res;
      end else if (drain) begin
         ob_in[0]  = ob_ff[1];
         ob_cnt_in = ob_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         held_ff   <= '0;
         begin_ff  <= '0;
         len_ff    <= '0;
         pos_ff    <= '0;
         cnt_ff    <= '0;
         stop_ff   <= 1'b0;
         ob_cnt_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         held_ff   <= held_in;
         begin_ff  <= begin_in;
         len_ff    <= len_in;
         pos_ff    <= pos_in;
         cnt_ff    <= cnt_in;
         stop_ff   <= stop_in;
         ob_cnt_ff <= ob_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ob_ff[0] <= ob_in[0];
      ob_ff[1] <= ob_in[1];
   end

   assign rsp_tvalid = (ob_cnt_ff != 2'd0);
   assign rsp_tdata  = {{(RSP_W - KIND_W - START_W - LEN_W - SYM_W){1'b0}},
                        ob_ff[0].tok.sym, ob_ff[0].tok.length,
                        ob_ff[0].tok.start, ob_ff[0].tok.kind};
   assign rsp_tlast  = ob_ff[0].last;

endmodule
